[rtl/lfb_pkg.sv]
// Shared types and constants for the LED flasher with burst repeat.
`timescale 1ns / 1ps
`default_nettype none

package lfb_pkg;

   localparam int CSR_INDEX_BITS = 3;
   localparam int COUNT_BITS     = 16;
   localparam int MIN_BURST      = 2;
   localparam int REQ_DATA_BITS  = 8;
   localparam int RSP_DATA_BITS  = 24;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_DRIVE_MODE   = 3'd0,
      CSR_ON_TIME      = 3'd1,
      CSR_OFF_TIME     = 3'd2,
      CSR_BURST_LENGTH = 3'd3,
      CSR_BURST_PERIOD = 3'd4,
      CSR_POLARITY     = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      MODE_STOPPED     = 2'd0,
      MODE_FLASHING    = 2'd1,
      MODE_FORCED_HIGH = 2'd2,
      MODE_FORCED_LOW  = 2'd3
   } drive_mode_type;

   // Packed from the top bit down, so pin_level lands in bit 0.
   typedef struct packed {
      logic [COUNT_BITS-1:0] toggle_total;
      logic                  toggled;
      logic                  pin_drive_enable;
      logic                  pin_level;
   } result_type;

endpackage

`default_nettype wire

[rtl/lfb_csr.sv]
// Configuration registers of the LED flasher.
`timescale 1ns / 1ps
`default_nettype none

module lfb_csr #(
   parameter int TIME_BITS  = 24,
   parameter int BURST_BITS = 8,
   parameter int CSR_BITS   = 24
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_wen,
   input  wire logic [lfb_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_BITS-1:0]                csr_wdata,
   output      lfb_pkg::drive_mode_type            drive_mode,
   output      logic [TIME_BITS-1:0]               on_time,
   output      logic [TIME_BITS-1:0]               off_time,
   output      logic [BURST_BITS-1:0]              burst_length,
   output      logic [TIME_BITS-1:0]               burst_period,
   output      logic                               polarity_inverted
);

   lfb_pkg::drive_mode_type drive_mode_ff;
   logic [TIME_BITS-1:0]    on_time_ff;
   logic [TIME_BITS-1:0]    off_time_ff;
   logic [BURST_BITS-1:0]   burst_length_ff;
   logic [TIME_BITS-1:0]    burst_period_ff;
   logic                    polarity_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         drive_mode_ff   <= lfb_pkg::MODE_STOPPED;
         on_time_ff      <= '0;
         off_time_ff     <= '0;
         burst_length_ff <= '0;
         burst_period_ff <= '0;
         polarity_ff     <= 1'b0;
      end else if (csr_wen) begin
         case (lfb_pkg::csr_index_type'(csr_index))
            lfb_pkg::CSR_DRIVE_MODE: begin
               drive_mode_ff <= lfb_pkg::drive_mode_type'(csr_wdata[1:0]);
            end
            lfb_pkg::CSR_ON_TIME: begin
               on_time_ff <= csr_wdata[TIME_BITS-1:0];
            end
            lfb_pkg::CSR_OFF_TIME: begin
               off_time_ff <= csr_wdata[TIME_BITS-1:0];
            end
            lfb_pkg::CSR_BURST_LENGTH: begin
               burst_length_ff <= csr_wdata[BURST_BITS-1:0];
            end
            lfb_pkg::CSR_BURST_PERIOD: begin
               burst_period_ff <= csr_wdata[TIME_BITS-1:0];
            end
            lfb_pkg::CSR_POLARITY: begin
               polarity_ff <= csr_wdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   assign drive_mode        = drive_mode_ff;
   assign on_time           = on_time_ff;
   assign off_time          = off_time_ff;
   assign burst_length      = burst_length_ff;
   assign burst_period      = burst_period_ff;
   assign polarity_inverted = polarity_ff;

endmodule

`default_nettype wire

[rtl/lfb_engine.sv]
// Flasher state, one-request update logic and the result register.
`timescale 1ns / 1ps
`default_nettype none

module lfb_engine #(
   parameter int TIME_BITS  = 24,
   parameter int BURST_BITS = 8
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    accept,
   input  wire logic                    tick,
   input  wire lfb_pkg::drive_mode_type drive_mode,
   input  wire logic [TIME_BITS-1:0]    on_time,
   input  wire logic [TIME_BITS-1:0]    off_time,
   input  wire logic [BURST_BITS-1:0]   burst_length,
   input  wire logic [TIME_BITS-1:0]    burst_period,
   input  wire logic                    polarity_inverted,
   output      lfb_pkg::result_type     result
);

   logic                           led_ff, led_in;
   logic [TIME_BITS-1:0]           since_toggle_ff, since_toggle_in;
   logic [TIME_BITS-1:0]           since_period_ff, since_period_in;
   logic [BURST_BITS-1:0]          flashes_ff, flashes_in;
   logic [lfb_pkg::COUNT_BITS-1:0] count_ff, count_in;
   lfb_pkg::result_type            result_ff, result_in;

   logic [TIME_BITS-1:0] st_ticked;
   logic [TIME_BITS-1:0] sp_ticked;
   logic                 on_lvl;
   logic                 burst;
   logic                 changed;

   always_comb begin
      st_ticked = since_toggle_ff;
      sp_ticked = since_period_ff;
      // Elapsed-time counters stick at all ones.
      if (tick && (since_toggle_ff != '1)) begin
         st_ticked = since_toggle_ff + TIME_BITS'(1);
      end
      if (tick && (since_period_ff != '1)) begin
         sp_ticked = since_period_ff + TIME_BITS'(1);
      end

      on_lvl  = ~polarity_inverted;
      burst   = (burst_length >= BURST_BITS'(lfb_pkg::MIN_BURST));
      changed = 1'b0;

      led_in          = led_ff;
      since_toggle_in = st_ticked;
      since_period_in = sp_ticked;
      flashes_in      = flashes_ff;
      count_in        = count_ff;

      result_in.pin_level        = 1'b0;
      result_in.pin_drive_enable = 1'b1;

      case (drive_mode)
         lfb_pkg::MODE_STOPPED: begin
            led_in                     = 1'b0;
            count_in                   = '0;
            flashes_in                 = '0;
            since_period_in            = '0;
            result_in.pin_drive_enable = 1'b0;
         end
         lfb_pkg::MODE_FORCED_HIGH: begin
            result_in.pin_level = 1'b1;
         end
         lfb_pkg::MODE_FORCED_LOW: begin
            result_in.pin_level = 1'b0;
         end
         lfb_pkg::MODE_FLASHING: begin
            if (!burst || (flashes_ff < burst_length)) begin
               // The on-to-off check has priority over off-to-on.
               if ((st_ticked > on_time) && (led_ff == on_lvl)) begin
                  led_in          = ~on_lvl;
                  since_toggle_in = '0;
                  changed         = 1'b1;
                  if (burst) begin
                     flashes_in = flashes_ff + BURST_BITS'(1);
                  end
               end else if ((st_ticked > off_time) && (led_ff != on_lvl)) begin
                  led_in          = on_lvl;
                  since_toggle_in = '0;
                  changed         = 1'b1;
               end
            end else if (sp_ticked > burst_period) begin
               since_period_in = '0;
               flashes_in      = '0;
               since_toggle_in = '0;
            end
            if (changed) begin
               count_in = count_ff + lfb_pkg::COUNT_BITS'(1);
            end
            result_in.pin_level = led_in;
         end
         default: begin
         end
      endcase

      result_in.toggled      = changed;
      result_in.toggle_total = count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         led_ff          <= 1'b0;
         since_toggle_ff <= '0;
         since_period_ff <= '0;
         flashes_ff      <= '0;
         count_ff        <= '0;
      end else if (accept) begin
         led_ff          <= led_in;
         since_toggle_ff <= since_toggle_in;
         since_period_ff <= since_period_in;
         flashes_ff      <= flashes_in;
         count_ff        <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

`default_nettype wire

[rtl/led_flasher_with_burst.sv]
// LED flasher with burst repeat: top level with stream handshake.
//
// Each request on the req_ channel is one evaluation of the flasher; bit 0
// of req_tdata says that one millisecond has passed before it. Every request
// produces exactly one response on the rsp_ channel carrying the pin level,
// the pin drive enable, whether the LED toggled and the running toggle count.
// Settings are written through the csr_ port (index, data, write enable) and
// take effect from the next request; write them only while the block is idle.
// A response appears in the cycle after the request; one request per cycle
// is taken as long as responses are consumed. The flasher state and the
// response register update together in the cycle a request is taken.
// When the receiver stalls, the pending response is held and req_tready
// drops until it is taken, so a new request can enter in the same cycle the
// old response leaves. Reset clears all settings (stopped mode), the
// flasher state and the response valid flag.
`timescale 1ns / 1ps
`default_nettype none

module led_flasher_with_burst #(
   parameter int TIME_BITS  = 24,
   parameter int BURST_BITS = 8
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // Request: bit 0 tick, other bits zero.
   input  wire logic                                req_tvalid,
   output      logic                                req_tready,
   input  wire logic [lfb_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   // Response: bit 0 pin_level, bit 1 pin_drive_enable, bit 2 toggled,
   // bits 18:3 toggle_total, rest zero.
   output      logic                                rsp_tvalid,
   input  wire logic                                rsp_tready,
   output      logic [lfb_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   input  wire logic                                csr_wen,
   input  wire logic [lfb_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [((TIME_BITS > BURST_BITS) ? TIME_BITS : BURST_BITS)-1:0] csr_wdata
);

   localparam int CsrBits = (TIME_BITS > BURST_BITS) ? TIME_BITS : BURST_BITS;

   lfb_pkg::drive_mode_type drive_mode;
   logic [TIME_BITS-1:0]    on_time;
   logic [TIME_BITS-1:0]    off_time;
   logic [BURST_BITS-1:0]   burst_length;
   logic [TIME_BITS-1:0]    burst_period;
   logic                    polarity_inverted;
   lfb_pkg::result_type     result;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    req_fire;
   logic                    rsp_fire;

   lfb_csr #(
      .TIME_BITS (TIME_BITS),
      .BURST_BITS(BURST_BITS),
      .CSR_BITS  (CsrBits)
   ) u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_wen          (csr_wen),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .drive_mode       (drive_mode),
      .on_time          (on_time),
      .off_time         (off_time),
      .burst_length     (burst_length),
      .burst_period     (burst_period),
      .polarity_inverted(polarity_inverted)
   );

   lfb_engine #(
      .TIME_BITS (TIME_BITS),
      .BURST_BITS(BURST_BITS)
   ) u_engine (
      .clock            (clock),
      .reset            (reset),
      .accept           (req_fire),
      .tick             (req_tdata[0]),
      .drive_mode       (drive_mode),
      .on_time          (on_time),
      .off_time         (off_time),
      .burst_length     (burst_length),
      .burst_period     (burst_period),
      .polarity_inverted(polarity_inverted),
      .result           (result)
   );

   // A new request may enter while the held response is being taken.
   assign req_tready = ~rsp_valid_ff | rsp_tready;
   assign req_fire   = req_tvalid & req_tready;
   assign rsp_fire   = rsp_valid_ff & rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_fire) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(lfb_pkg::RSP_DATA_BITS - $bits(lfb_pkg::result_type)){1'b0}},
                        result};

   // Every taken request shows up as a response in the next cycle.
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_tvalid)
      else $error("request taken but no response followed");

   // A tri-stated pin means stopped mode: level low, no toggle, count cleared.
   a_stopped_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tdata[1]) |->
         (!rsp_tdata[0] && !rsp_tdata[2] && (rsp_tdata[18:3] == 16'd0)))
      else $error("stopped response carries a level, toggle or count");

   // A toggle reported while the previous response was stopped counts as one.
   a_first_toggle: assert property (@(posedge clock) disable iff (reset)
      (req_fire && rsp_tvalid && !rsp_tdata[1]) |=>
         (!result.toggled || (result.toggle_total == 16'd1)))
      else $error("toggle count did not restart from zero after stop");

endmodule

`default_nettype wire
